// ===== design/wsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_pkg - shared types and constants for the window settling detector
// Word layouts of both channels, field widths, codes and sequencer states.
// ----------------------------------------------------------------------------
package wsd_pkg;

   // window depth default
   localparam int WINDOW_DEFAULT = 50;

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int FILL_W   = 6;
   localparam int TOL_W    = 16;
   localparam int FRAC_W   = 16;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_TOLERANCE = 1'b0;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd6554;

   // function codes
   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // input word
   typedef struct packed {
      logic                       func;
      logic signed [SAMPLE_W-1:0] sample;
   } req_word_type;

   // result word
   typedef struct packed {
      logic                       stable;
      logic signed [SAMPLE_W-1:0] window_mean;
      logic [FILL_W-1:0]          fill_count;
   } rsp_word_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_SCAN,
      ST_MUL,
      ST_CMP,
      ST_DONE
   } wsd_state_type;

endpackage : wsd_pkg
`default_nettype wire

// ===== design/window_settling_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// window_settling_detector - settling detector over a sliding sample window
// Ring buffer of the last WINDOW samples with fill count and running sum.
// Each word returns the stable flag, the window mean and the fill count.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake        word
//   req       in         valid / stall    req_word_type (func, sample)
//   rsp       out        valid / stall    rsp_word_type (stable, mean, fill)
//   csr       in/out     apb write/read   tolerance_q16 at byte address 0
//
// A clear word goes from accept straight to the done state, which loads the
// result register once it is free. A push word passes through fetch,
// update, divider load, the one-bit-per-cycle restoring divider and done;
// when the window is full with a nonzero sum, the min/max scan through the
// ring RAM read port, the multiply state and the compare state come before
// done; a negative sum skips the compare state.
// The next word is accepted in the cycle after the result register loads.
// Synchronous reset empties the window and restores the tolerance; the ring
// RAM is not cleared. A stalled result holds in its register while the
// next word is already accepted and worked on.
// ----------------------------------------------------------------------------
module window_settling_detector
   import wsd_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_word_type          req_word,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_word_type               rsp_word,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   // derived widths
   localparam int ADDR_W  = $clog2(WINDOW);
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
   localparam int DCNT_W  = $clog2(SUM_W + 1);
   localparam int RANGE_W = SAMPLE_W + 1;
   localparam int PROD_W  = RANGE_W + CNT_W;
   localparam int TSUM_W  = TOL_W + SUM_W;
   localparam int CMP_W   = PROD_W + FRAC_W + TOL_W + SUM_W;

   // registers
   wsd_state_type              state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [ADDR_W-1:0]          slot_ff, slot_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [TOL_W-1:0]           tol_ff, tol_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [SUM_W-1:0]           quo_ff, quo_in;
   logic                       neg_ff, neg_in;
   logic [DCNT_W-1:0]          step_ff, step_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic                       stable_ff, stable_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_word_type               rsp_word_ff, rsp_word_in;

   // ring RAM signals
   logic                       ram_wr_en;
   logic [ADDR_W-1:0]          ram_wr_addr;
   logic                       ram_rd_en;
   logic [ADDR_W-1:0]          ram_rd_addr;
   logic [SAMPLE_W-1:0]        ram_rd_data;

   // datapath helpers
   logic                       full;
   logic signed [SAMPLE_W-1:0] ram_sample;
   logic [SUM_W-1:0]           old_ext;
   logic [SUM_W-1:0]           new_ext;
   logic [CNT_W:0]             partial;
   logic [CNT_W+1:0]           trial;
   logic [RANGE_W-1:0]         range;
   logic [TSUM_W-1:0]          tol_prod;
   logic [CMP_W-1:0]           cmp_lhs;
   logic [CMP_W-1:0]           cmp_rhs;
   logic [SAMPLE_W-1:0]        quo_low;
   logic                       csr_write;

   wsd_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(WINDOW)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(sample_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_IDX_TOLERANCE) ?
                      {{(CSR_DATA_W-TOL_W){1'b0}}, tol_ff} : '0;

   // handshake outputs
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // shared datapath terms
   assign full       = (count_ff == CNT_W'(WINDOW));
   assign ram_sample = ram_rd_data;
   assign old_ext    = {{(SUM_W-SAMPLE_W){ram_sample[SAMPLE_W-1]}}, ram_sample};
   assign new_ext    = {{(SUM_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
   assign partial    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial      = {1'b0, partial} - {2'b00, count_ff};
   assign range      = RANGE_W'({max_ff[SAMPLE_W-1], max_ff}
                                - {min_ff[SAMPLE_W-1], min_ff});
   assign tol_prod   = TSUM_W'(tol_ff) * TSUM_W'($unsigned(sum_ff));
   assign cmp_lhs    = CMP_W'({prod_ff, {FRAC_W{1'b0}}});
   assign cmp_rhs    = CMP_W'(tol_prod);
   assign quo_low    = quo_ff[SAMPLE_W-1:0];

   // sequencer: next state and datapath
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      tol_in       = tol_ff;
      sample_in    = sample_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      prod_in      = prod_ff;
      stable_in    = stable_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = slot_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = slot_ff;

      // tolerance register
      if (csr_write && (paddr[2] == CSR_IDX_TOLERANCE)) begin
         tol_in = pwdata[TOL_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_word.sample;
               if (req_word.func == FUNC_CLEAR) begin
                  count_in  = '0;
                  slot_in   = '0;
                  sum_in    = '0;
                  quo_in    = '0;
                  neg_in    = 1'b0;
                  stable_in = 1'b0;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         // read the oldest sample at the write slot
         ST_FETCH: begin
            ram_rd_en = 1'b1;
            state_in  = ST_UPDATE;
         end
         // store the new sample, evict the oldest once full
         ST_UPDATE: begin
            ram_wr_en = 1'b1;
            if (full) begin
               sum_in = sum_ff - signed'(old_ext) + signed'(new_ext);
            end else begin
               sum_in   = sum_ff + signed'(new_ext);
               count_in = count_ff + CNT_W'(1);
            end
            slot_in  = (slot_ff == ADDR_W'(WINDOW - 1)) ? '0 : slot_ff + ADDR_W'(1);
            state_in = ST_DIV_LOAD;
         end
         // load divider with the sum magnitude
         ST_DIV_LOAD: begin
            neg_in   = sum_ff[SUM_W-1];
            quo_in   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
            rem_in   = '0;
            step_in  = DCNT_W'(SUM_W);
            state_in = ST_DIVIDE;
         end
         // restoring divide, one quotient bit per cycle
         ST_DIVIDE: begin
            if (!trial[CNT_W+1]) begin
               rem_in = trial[CNT_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = partial[CNT_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            step_in = step_ff - DCNT_W'(1);
            if (step_ff == DCNT_W'(1)) begin
               stable_in = 1'b0;
               idx_in    = '0;
               if (full && (sum_ff != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         // min/max sweep over the ring, read data trails the address through the RAM read register
         ST_SCAN: begin
            ram_rd_en   = (idx_ff < CNT_W'(WINDOW));
            ram_rd_addr = idx_ff[ADDR_W-1:0];
            if (idx_ff == CNT_W'(1)) begin
               min_in = ram_sample;
               max_in = ram_sample;
            end else if (idx_ff != '0) begin
               if (ram_sample < min_ff) begin
                  min_in = ram_sample;
               end
               if (ram_sample > max_ff) begin
                  max_in = ram_sample;
               end
            end
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(WINDOW)) begin
               state_in = ST_MUL;
            end
         end
         // range times window; negative mean is settled unless range and tolerance are both zero
         ST_MUL: begin
            prod_in = PROD_W'(range) * PROD_W'(WINDOW);
            if (sum_ff[SUM_W-1]) begin
               stable_in = (range != '0) || (tol_ff != '0);
               state_in  = ST_DONE;
            end else begin
               state_in = ST_CMP;
            end
         end
         // spread against tolerance times sum
         ST_CMP: begin
            stable_in = (cmp_lhs < cmp_rhs);
            state_in  = ST_DONE;
         end
         // hand the word to the result register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.stable      = stable_ff;
               rsp_word_in.window_mean = neg_ff ? -quo_low : quo_low;
               rsp_word_in.fill_count  = FILL_W'(count_ff);
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      prod_ff     <= prod_in;
      stable_ff   <= stable_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule : window_settling_detector
`default_nettype wire

// ===== design/wsd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wsd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 50
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : wsd_ram
`default_nettype wire
